/* rtl/pagerank_push_engine_top_macros.svh */
// Assertion macros for the PageRank push engine.
// Uses clk and rst_n of the including module.
`ifndef PAGERANK_PUSH_ENGINE_TOP_MACROS_SVH
`define PAGERANK_PUSH_ENGINE_TOP_MACROS_SVH

// implication checked on every edge out of reset
`define PPE_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// invariant checked on every edge out of reset
`define PPE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

/* rtl/ppe_pkg.sv */
// Package for the PageRank push engine: codes, field widths, sequencer states.
// No dependencies.
package ppe_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 4096;

    localparam int NC_W    = 11;
    localparam int IT_W    = 8;
    localparam int LAM_W   = 16;
    localparam int FUNC_W  = 2;
    localparam int DEST_W  = 10;
    localparam int RAW_W   = 16;
    localparam int WT_W    = 17;
    localparam int RANK_W  = 32;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [RANK_W-1:0] RANK_ONE = 32'h8000_0000;
    localparam logic [WT_W-1:0]   WT_ONE   = 17'h1_0000;

    localparam logic [FUNC_W-1:0] FUNC_ROW  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EDGE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RUN  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_OVF  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_DONE = 2'd2;

    localparam logic [1:0] REG_NODE_COUNT   = 2'd0;
    localparam logic [1:0] REG_ITERATIONS   = 2'd1;
    localparam logic [1:0] REG_RESTART_PROB = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_N_ROW,
        S_N_BEG,
        S_N_END,
        S_N_SUM_RD,
        S_N_SUM_AC,
        S_N_DIV_RD,
        S_N_DIV_ST,
        S_N_WR,
        S_INIT,
        S_INIT_LAM,
        S_INIT_SAVE,
        S_FILL,
        S_CLR,
        S_P_ROW,
        S_P_RANK,
        S_P_END,
        S_P_EDGE_RD,
        S_P_MUL,
        S_P_ACC,
        S_SINK_DIV,
        S_SINK_SAVE,
        S_M_RD,
        S_M_LO,
        S_M_HI,
        S_M_WR,
        S_DIV,
        S_DONE
    } ppe_state_t;

endpackage

/* rtl/pagerank_push_engine_top.sv */
// PageRank push engine top level: load, normalize, push passes, rank readout.
// Depends on ppe_pkg, ppe_ram and pagerank_push_engine_top_macros.svh.
//
// Input channel (in_valid/in_ready) carries func, dest_node, weight.
// Open row and append edge complete in the transfer cycle, so loads sustain
// one item per cycle while the receiver does not stall a held result.
// Read rank: rank store read data goes to the result register, with no input
// taken meanwhile. Nodes outside the store read zero without a memory access.
// Run: the sequencer works through the graph with one shared 32x17
// multiplier and one restoring divider (one quotient bit per cycle).
// A run normalizes rows with a nonzero weight sum, does two divides for the
// initial rank and the restart term, fills the rank store, then per pass
// clears the accumulators, pushes along the edges, does one divide for the
// sink share and mixes in the restart term.
// in_ready is low for the whole run.
// Result channel (out_valid/out_ready) has one output register; a stalled
// receiver holds it and blocks every new item.
// Reset clears row and edge counts and overflow flag, restores config
// defaults; graph and rank memories hold garbage until written.
`include "pagerank_push_engine_top_macros.svh"

module pagerank_push_engine_top
    import ppe_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic [DEST_W-1:0]  dest_node,
    input  logic [RAW_W-1:0]   weight,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [RANK_W-1:0]  rank,
    output logic [STAT_W-1:0]  status
);

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int NCNT_W  = $clog2(MAX_NODES + 1);
    localparam int EDGE_W  = $clog2(MAX_EDGES);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int SUM_W   = WT_W + ECNT_W;
    localparam int SINK_W  = RANK_W + NODE_W;
    localparam int ACC_A   = RANK_W + NODE_W;
    localparam int ACC_B   = 16 + EDGE_W;
    localparam int ACC_W   = ((ACC_A > ACC_B) ? ACC_A : ACC_B) + 1;
    localparam int INNER_W = ACC_W + 1;
    localparam int HI_W    = INNER_W - RANK_W;
    localparam int PROD_W  = RANK_W + WT_W;
    localparam int MIX_W   = INNER_W + WT_W;
    localparam int VAL_W   = MIX_W + 1 - 16;
    localparam int DVD_W   = ((SINK_W > SUM_W) ? SINK_W : SUM_W) + 1;
    localparam int DVS_W   = SUM_W;
    localparam int DCNT_W  = $clog2(DVD_W);

    // sequencer
    ppe_state_t state_reg, state_next;
    ppe_state_t div_ret_reg, div_ret_next;

    // configuration
    logic [NC_W-1:0]  node_count_reg;
    logic [IT_W-1:0]  iterations_reg;
    logic [LAM_W-1:0] restart_prob_reg;
    logic             cfg_write;

    // load state
    logic [NCNT_W-1:0] rows_reg, rows_next;
    logic [ECNT_W-1:0] edges_reg, edges_next;
    logic              ovf_reg, ovf_next;

    // result register
    logic              out_valid_reg;
    logic [RANK_W-1:0] rank_reg;
    logic [STAT_W-1:0] status_reg;
    logic              out_load;
    logic [RANK_W-1:0] out_rank_d;
    logic [STAT_W-1:0] out_status_d;

    // datapath registers
    logic [NCNT_W-1:0]  n_reg, n_next;
    logic [IT_W-1:0]    pass_reg, pass_next;
    logic [NCNT_W-1:0]  i_reg, i_next;
    logic [ECNT_W-1:0]  j_reg, j_next;
    logic [ECNT_W-1:0]  b_reg, b_next;
    logic [ECNT_W-1:0]  e_reg, e_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [RANK_W-1:0]  cur_rank_reg, cur_rank_next;
    logic [SINK_W-1:0]  sinks_reg, sinks_next;
    logic [RANK_W-1:0]  lam_term_reg, lam_term_next;
    logic [RANK_W-1:0]  sink_term_reg, sink_term_next;
    logic [INNER_W-1:0] inner_reg, inner_next;
    logic [PROD_W-1:0]  mix_reg, mix_next;
    logic [DEST_W-1:0]  dest_reg, dest_next;
    logic [DVD_W-1:0]   dq_reg, dq_next;
    logic [DVS_W-1:0]   rem_reg, rem_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;

    // shared multiplier operands
    logic [RANK_W-1:0] mul_a;
    logic [WT_W-1:0]   mul_b;

    // memory ports
    logic              rs_we, ed_we, ew_we, rk_we, nr_we;
    logic [NODE_W-1:0] rs_waddr, rs_raddr, rk_waddr, rk_raddr, nr_waddr, nr_raddr;
    logic [EDGE_W-1:0] ed_waddr, ed_raddr, ew_waddr, ew_raddr;
    logic [ECNT_W-1:0] rs_wdata, rs_rdata;
    logic [DEST_W-1:0] ed_rdata;
    logic [WT_W-1:0]   ew_wdata, ew_rdata;
    logic [RANK_W-1:0] rk_wdata, rk_rdata;
    logic [ACC_W-1:0]  nr_wdata, nr_rdata;

    // combinational helpers
    logic               in_accept;
    logic [NCNT_W-1:0]  n_eff;
    logic               read_ok;
    logic               row_last;
    logic [ECNT_W-1:0]  e_val;
    logic [WT_W-1:0]    keep;
    logic               dest_in;
    logic [PROD_W:0]    push_term;
    logic [INNER_W-1:0] inner_val;
    logic [MIX_W:0]     mix_full;
    logic [VAL_W:0]     val_sum;
    logic [RANK_W-1:0]  rank_val;
    logic [DVS_W:0]     rem_sh;
    logic               div_ge;
    logic               div_last;

    ppe_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_NODES)) u_row_start (
        .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
        .raddr(rs_raddr), .rdata(rs_rdata)
    );

    ppe_ram #(.WIDTH(DEST_W), .DEPTH(MAX_EDGES)) u_edge_dest (
        .clk(clk), .we(ed_we), .waddr(ed_waddr), .wdata(dest_node),
        .raddr(ed_raddr), .rdata(ed_rdata)
    );

    ppe_ram #(.WIDTH(WT_W), .DEPTH(MAX_EDGES)) u_edge_weight (
        .clk(clk), .we(ew_we), .waddr(ew_waddr), .wdata(ew_wdata),
        .raddr(ew_raddr), .rdata(ew_rdata)
    );

    ppe_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rank (
        .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
        .raddr(rk_raddr), .rdata(rk_rdata)
    );

    ppe_ram #(.WIDTH(ACC_W), .DEPTH(MAX_NODES)) u_next_rank (
        .clk(clk), .we(nr_we), .waddr(nr_waddr), .wdata(nr_wdata),
        .raddr(nr_raddr), .rdata(nr_rdata)
    );

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_NODE_COUNT:   prdata = PDATA_W'(node_count_reg);
            REG_ITERATIONS:   prdata = PDATA_W'(iterations_reg);
            REG_RESTART_PROB: prdata = PDATA_W'(restart_prob_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- handshake and helpers ----------------
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign rank      = rank_reg;
    assign status    = status_reg;

    assign n_eff = (node_count_reg == '0) ? NCNT_W'(1) :
                   ((32'(node_count_reg) > MAX_NODES) ? NCNT_W'(MAX_NODES) :
                    NCNT_W'(node_count_reg));
    assign read_ok   = 32'(dest_node) < MAX_NODES;
    assign row_last  = !(((NCNT_W+1)'(i_reg) + (NCNT_W+1)'(1)) < (NCNT_W+1)'(rows_reg));
    assign e_val     = row_last ? edges_reg : rs_rdata;
    assign keep      = WT_ONE - WT_W'(restart_prob_reg);
    assign dest_in   = 32'(ed_rdata) < 32'(n_reg);
    assign push_term = ((PROD_W+1)'(prod_reg) + (PROD_W+1)'(32768)) >> 16;
    assign inner_val = INNER_W'(sink_term_reg) + INNER_W'(nr_rdata);
    assign mix_full  = (MIX_W+1)'(mix_reg) + ((MIX_W+1)'(prod_reg) << RANK_W)
                       + (MIX_W+1)'(32768);
    assign val_sum   = (VAL_W+1)'(lam_term_reg) + (VAL_W+1)'(mix_full >> 16);
    assign rank_val  = (val_sum > (VAL_W+1)'(RANK_ONE)) ? RANK_ONE : val_sum[RANK_W-1:0];
    assign rem_sh    = {rem_reg, dq_reg[DVD_W-1]};
    assign div_ge    = rem_sh >= {1'b0, dvs_reg};
    assign div_last  = dcnt_reg == DCNT_W'(DVD_W - 1);
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (func == FUNC_RUN)
                    begin
                        state_next = S_N_ROW;
                    end
                    else if (func == FUNC_READ && read_ok)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:      state_next = S_IDLE;
            S_N_ROW:     state_next = (i_reg >= rows_reg) ? S_INIT : S_N_BEG;
            S_N_BEG:     state_next = S_N_END;
            S_N_END:     state_next = S_N_SUM_RD;
            S_N_SUM_RD:
            begin
                if (j_reg < e_reg)
                begin
                    state_next = S_N_SUM_AC;
                end
                else
                begin
                    state_next = (sum_reg != '0) ? S_N_DIV_RD : S_N_ROW;
                end
            end
            S_N_SUM_AC:  state_next = S_N_SUM_RD;
            S_N_DIV_RD:  state_next = (j_reg < e_reg) ? S_N_DIV_ST : S_N_ROW;
            S_N_DIV_ST:  state_next = S_DIV;
            S_N_WR:      state_next = S_N_DIV_RD;
            S_INIT:      state_next = S_DIV;
            S_INIT_LAM:  state_next = S_DIV;
            S_INIT_SAVE: state_next = S_FILL;
            S_FILL:      state_next = (i_reg < n_reg) ? S_FILL : S_CLR;
            S_CLR:       state_next = (i_reg < n_reg) ? S_CLR : S_P_ROW;
            S_P_ROW:     state_next = (i_reg < n_reg) ? S_P_RANK : S_SINK_DIV;
            S_P_RANK:    state_next = (i_reg >= rows_reg) ? S_P_ROW : S_P_END;
            S_P_END:     state_next = (j_reg >= e_val) ? S_P_ROW : S_P_EDGE_RD;
            S_P_EDGE_RD: state_next = (j_reg < e_reg) ? S_P_MUL : S_P_ROW;
            S_P_MUL:     state_next = dest_in ? S_P_ACC : S_P_EDGE_RD;
            S_P_ACC:     state_next = S_P_EDGE_RD;
            S_SINK_DIV:  state_next = S_DIV;
            S_SINK_SAVE: state_next = S_M_RD;
            S_M_RD:
            begin
                if (i_reg < n_reg)
                begin
                    state_next = S_M_LO;
                end
                else
                begin
                    state_next = (pass_reg == iterations_reg) ? S_DONE : S_CLR;
                end
            end
            S_M_LO:      state_next = S_M_HI;
            S_M_HI:      state_next = S_M_WR;
            S_M_WR:      state_next = S_M_RD;
            S_DIV:       state_next = div_last ? div_ret_reg : S_DIV;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // ---------------- datapath and memory control ----------------
    always_comb
    begin
        div_ret_next   = div_ret_reg;
        rows_next      = rows_reg;
        edges_next     = edges_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        pass_next      = pass_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        b_next         = b_reg;
        e_next         = e_reg;
        sum_next       = sum_reg;
        cur_rank_next  = cur_rank_reg;
        sinks_next     = sinks_reg;
        lam_term_next  = lam_term_reg;
        sink_term_next = sink_term_reg;
        inner_next     = inner_reg;
        mix_next       = mix_reg;
        dest_next      = dest_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        dcnt_next      = dcnt_reg;
        mul_a          = '0;
        mul_b          = '0;
        out_load       = 1'b0;
        out_rank_d     = '0;
        out_status_d   = STATUS_OK;
        rs_we          = 1'b0;
        rs_waddr       = NODE_W'(rows_reg);
        rs_wdata       = edges_reg;
        rs_raddr       = NODE_W'(i_reg);
        ed_we          = 1'b0;
        ed_waddr       = EDGE_W'(edges_reg);
        ed_raddr       = EDGE_W'(j_reg);
        ew_we          = 1'b0;
        ew_waddr       = EDGE_W'(edges_reg);
        ew_wdata       = WT_W'(weight);
        ew_raddr       = EDGE_W'(j_reg);
        rk_we          = 1'b0;
        rk_waddr       = NODE_W'(i_reg);
        rk_wdata       = cur_rank_reg;
        rk_raddr       = NODE_W'(i_reg);
        nr_we          = 1'b0;
        nr_waddr       = NODE_W'(i_reg);
        nr_wdata       = '0;
        nr_raddr       = NODE_W'(i_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (func)
                        FUNC_ROW:
                        begin
                            if (rows_reg >= NCNT_W'(MAX_NODES))
                            begin
                                ovf_next     = 1'b1;
                                out_load     = 1'b1;
                                out_status_d = STATUS_OVF;
                            end
                            else
                            begin
                                rs_we     = 1'b1;
                                rows_next = rows_reg + NCNT_W'(1);
                            end
                        end
                        FUNC_EDGE:
                        begin
                            if (edges_reg >= ECNT_W'(MAX_EDGES))
                            begin
                                ovf_next     = 1'b1;
                                out_load     = 1'b1;
                                out_status_d = STATUS_OVF;
                            end
                            else
                            begin
                                ed_we      = 1'b1;
                                ew_we      = 1'b1;
                                edges_next = edges_reg + ECNT_W'(1);
                            end
                        end
                        FUNC_RUN:
                        begin
                            n_next = n_eff;
                            i_next = '0;
                        end
                        FUNC_READ:
                        begin
                            rk_raddr = NODE_W'(dest_node);
                            if (!read_ok)
                            begin
                                out_load = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_load   = 1'b1;
                out_rank_d = rk_rdata;
            end
            S_N_BEG:
            begin
                b_next   = rs_rdata;
                j_next   = rs_rdata;
                rs_raddr = NODE_W'(i_reg + NCNT_W'(1));
            end
            S_N_END:
            begin
                e_next   = e_val;
                sum_next = '0;
            end
            S_N_SUM_RD:
            begin
                if (j_reg >= e_reg)
                begin
                    if (sum_reg != '0)
                    begin
                        j_next = b_reg;
                    end
                    else
                    begin
                        i_next = i_reg + NCNT_W'(1);
                    end
                end
            end
            S_N_SUM_AC:
            begin
                sum_next = sum_reg + SUM_W'(ew_rdata);
                j_next   = j_reg + ECNT_W'(1);
            end
            S_N_DIV_RD:
            begin
                if (j_reg >= e_reg)
                begin
                    i_next = i_reg + NCNT_W'(1);
                end
            end
            S_N_DIV_ST:
            begin
                dq_next      = DVD_W'({ew_rdata, 16'b0}) + DVD_W'(sum_reg >> 1);
                dvs_next     = sum_reg;
                rem_next     = '0;
                dcnt_next    = '0;
                div_ret_next = S_N_WR;
            end
            S_N_WR:
            begin
                ew_we    = 1'b1;
                ew_waddr = EDGE_W'(j_reg);
                ew_wdata = WT_W'(dq_reg);
                j_next   = j_reg + ECNT_W'(1);
            end
            S_INIT:
            begin
                dq_next      = DVD_W'(RANK_ONE) + DVD_W'(n_reg >> 1);
                dvs_next     = DVS_W'(n_reg);
                rem_next     = '0;
                dcnt_next    = '0;
                div_ret_next = S_INIT_LAM;
            end
            S_INIT_LAM:
            begin
                cur_rank_next = RANK_W'(dq_reg);
                dq_next       = DVD_W'({restart_prob_reg, 15'b0}) + DVD_W'(n_reg >> 1);
                dvs_next      = DVS_W'(n_reg);
                rem_next      = '0;
                dcnt_next     = '0;
                div_ret_next  = S_INIT_SAVE;
            end
            S_INIT_SAVE:
            begin
                lam_term_next = RANK_W'(dq_reg);
                i_next        = '0;
            end
            S_FILL:
            begin
                if (i_reg < n_reg)
                begin
                    rk_we  = 1'b1;
                    i_next = i_reg + NCNT_W'(1);
                end
                else
                begin
                    i_next    = '0;
                    pass_next = '0;
                end
            end
            S_CLR:
            begin
                if (i_reg < n_reg)
                begin
                    nr_we  = 1'b1;
                    i_next = i_reg + NCNT_W'(1);
                end
                else
                begin
                    i_next     = '0;
                    sinks_next = '0;
                end
            end
            S_P_RANK:
            begin
                cur_rank_next = rk_rdata;
                j_next        = rs_rdata;
                rs_raddr      = NODE_W'(i_reg + NCNT_W'(1));
                if (i_reg >= rows_reg)
                begin
                    sinks_next = sinks_reg + SINK_W'(rk_rdata);
                    i_next     = i_reg + NCNT_W'(1);
                end
            end
            S_P_END:
            begin
                e_next = e_val;
                if (j_reg >= e_val)
                begin
                    sinks_next = sinks_reg + SINK_W'(cur_rank_reg);
                    i_next     = i_reg + NCNT_W'(1);
                end
            end
            S_P_EDGE_RD:
            begin
                if (j_reg >= e_reg)
                begin
                    i_next = i_reg + NCNT_W'(1);
                end
            end
            S_P_MUL:
            begin
                mul_a     = cur_rank_reg;
                mul_b     = ew_rdata;
                dest_next = ed_rdata;
                nr_raddr  = NODE_W'(ed_rdata);
                if (!dest_in)
                begin
                    j_next = j_reg + ECNT_W'(1);
                end
            end
            S_P_ACC:
            begin
                nr_we    = 1'b1;
                nr_waddr = NODE_W'(dest_reg);
                nr_wdata = nr_rdata + ACC_W'(push_term);
                j_next   = j_reg + ECNT_W'(1);
            end
            S_SINK_DIV:
            begin
                dq_next      = DVD_W'(sinks_reg) + DVD_W'(n_reg >> 1);
                dvs_next     = DVS_W'(n_reg);
                rem_next     = '0;
                dcnt_next    = '0;
                div_ret_next = S_SINK_SAVE;
            end
            S_SINK_SAVE:
            begin
                sink_term_next = RANK_W'(dq_reg);
                i_next         = '0;
            end
            S_M_RD:
            begin
                if (!(i_reg < n_reg) && (pass_reg != iterations_reg))
                begin
                    pass_next = pass_reg + IT_W'(1);
                    i_next    = '0;
                end
            end
            S_M_LO:
            begin
                inner_next = inner_val;
                mul_a      = inner_val[RANK_W-1:0];
                mul_b      = keep;
            end
            S_M_HI:
            begin
                mix_next = prod_reg;
                mul_a    = RANK_W'(inner_reg[INNER_W-1 -: HI_W]);
                mul_b    = keep;
            end
            S_M_WR:
            begin
                rk_we    = 1'b1;
                rk_wdata = rank_val;
                i_next   = i_reg + NCNT_W'(1);
            end
            S_DIV:
            begin
                rem_next  = div_ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : DVS_W'(rem_sh);
                dq_next   = {dq_reg[DVD_W-2:0], div_ge};
                dcnt_next = dcnt_reg + DCNT_W'(1);
            end
            S_DONE:
            begin
                out_load     = 1'b1;
                out_status_d = ovf_reg ? STATUS_OVF : STATUS_DONE;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            div_ret_reg      <= S_IDLE;
            node_count_reg   <= NC_W'(1);
            iterations_reg   <= IT_W'(10);
            restart_prob_reg <= LAM_W'(13107);
            rows_reg         <= '0;
            edges_reg        <= '0;
            ovf_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            div_ret_reg <= div_ret_next;
            rows_reg    <= rows_next;
            edges_reg   <= edges_next;
            ovf_reg     <= ovf_next;
            if (cfg_write)
            begin
                case (paddr[3:2])
                    REG_NODE_COUNT:   node_count_reg   <= pwdata[NC_W-1:0];
                    REG_ITERATIONS:   iterations_reg   <= pwdata[IT_W-1:0];
                    REG_RESTART_PROB: restart_prob_reg <= pwdata[LAM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rank_reg   <= out_rank_d;
            status_reg <= out_status_d;
        end
        n_reg         <= n_next;
        pass_reg      <= pass_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        b_reg         <= b_next;
        e_reg         <= e_next;
        sum_reg       <= sum_next;
        cur_rank_reg  <= cur_rank_next;
        sinks_reg     <= sinks_next;
        lam_term_reg  <= lam_term_next;
        sink_term_reg <= sink_term_next;
        inner_reg     <= inner_next;
        mix_reg       <= mix_next;
        dest_reg      <= dest_next;
        dq_reg        <= dq_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        dcnt_reg      <= dcnt_next;
        prod_reg      <= prod_next;
    end

    // ---------------- assertions ----------------
    `PPE_ASSERT_IMP(a_no_result_overwrite, out_load, !out_valid_reg || out_ready,
        "result register overwritten before transfer")
    `PPE_ASSERT_IMP(a_busy_not_ready, state_reg != S_IDLE, !in_ready,
        "input taken while sequencer busy")
    `PPE_ASSERT_ALWAYS(a_load_bounds,
        (32'(rows_reg) <= MAX_NODES) && (32'(edges_reg) <= MAX_EDGES),
        "row or edge count beyond store size")

endmodule

/* rtl/ppe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* tb/sv/pagerank_push_engine_top_tb.sv */
// Testbench for pagerank_push_engine_top: loads CSR graphs, runs push passes
// and reads ranks, checked against a fixed-point predictor in a scoreboard.
// Depends on ppe_pkg and the RTL of pagerank_push_engine_top.
module pagerank_push_engine_top_tb
    import ppe_pkg::*;
();

    localparam int NODE_CAP = 1024;
    localparam int EDGE_CAP = 4096;
    localparam longint LIMIT = 40_000_000;

    typedef struct {
        logic [RANK_W-1:0] rank;
        logic [STAT_W-1:0] status;
    } rank_result_t;

    class rank_scoreboard;
        int unsigned node_count = 1;
        int unsigned iters = 10;
        longint unsigned lambda = 13107;
        longint unsigned row_start [NODE_CAP+1];
        longint unsigned edge_dest [EDGE_CAP];
        longint unsigned edge_wt [EDGE_CAP];
        longint unsigned rank_st [NODE_CAP];
        longint unsigned next_st [NODE_CAP];
        int unsigned rows_loaded = 0;
        int unsigned edges_loaded = 0;
        bit ovf = 0;
        rank_result_t pending[$];
        int errors = 0;
        int checked = 0;
        int items = 0;
        int runs = 0;

        function void set_reg(logic [1:0] idx, int unsigned v);
            if (idx == REG_NODE_COUNT)
                node_count = v & 32'h7FF;
            else if (idx == REG_ITERATIONS)
                iters = v & 32'hFF;
            else if (idx == REG_RESTART_PROB)
                lambda = v & 32'hFFFF;
        endfunction

        function longint unsigned row_end(int unsigned r);
            if (r + 1 < rows_loaded)
                return row_start[r+1];
            return edges_loaded;
        endfunction

        function void normalize_rows();
            longint unsigned sum;
            longint unsigned b;
            longint unsigned e;
            for (int unsigned r = 0; r < rows_loaded; r++)
            begin
                b = row_start[r];
                e = row_end(r);
                sum = 0;
                for (longint unsigned j = b; j < e; j++)
                    sum += edge_wt[j];
                if (sum != 0)
                begin
                    for (longint unsigned j = b; j < e; j++)
                        edge_wt[j] = ((edge_wt[j] << 16) + sum / 2) / sum;
                end
            end
        endfunction

        function void run_passes();
            int unsigned n;
            longint unsigned keep;
            longint unsigned lam_term;
            longint unsigned sinks;
            longint unsigned sink_term;
            longint unsigned inner;
            longint unsigned v;
            longint unsigned b;
            longint unsigned e;
            n = node_count;
            if (n < 1) n = 1;
            if (n > NODE_CAP) n = NODE_CAP;
            normalize_rows();
            for (int unsigned i = 0; i < n; i++)
                rank_st[i] = ((64'd1 << 31) + n / 2) / n;
            keep = 65536 - lambda;
            lam_term = ((lambda << 15) + n / 2) / n;
            for (int unsigned p = 0; p <= iters; p++)
            begin
                sinks = 0;
                for (int unsigned i = 0; i < n; i++)
                    next_st[i] = 0;
                for (int unsigned i = 0; i < n; i++)
                begin
                    if (i >= rows_loaded)
                        sinks += rank_st[i];
                    else
                    begin
                        b = row_start[i];
                        e = row_end(i);
                        if (b >= e)
                            sinks += rank_st[i];
                        else
                            for (longint unsigned j = b; j < e; j++)
                                if (edge_dest[j] < n)
                                    next_st[edge_dest[j]] +=
                                        (rank_st[i] * edge_wt[j] + 32768) >> 16;
                    end
                end
                sink_term = (sinks + n / 2) / n;
                for (int unsigned i = 0; i < n; i++)
                begin
                    inner = sink_term + next_st[i];
                    v = lam_term + ((inner * keep + 32768) >> 16);
                    if (v > (64'd1 << 31))
                        v = 64'd1 << 31;
                    rank_st[i] = v;
                end
            end
        endfunction

        function void note_input(logic [FUNC_W-1:0] f, logic [DEST_W-1:0] d,
                                 logic [RAW_W-1:0] w);
            rank_result_t res;
            items++;
            res.rank = '0;
            if (f == FUNC_ROW)
            begin
                if (rows_loaded >= NODE_CAP)
                begin
                    ovf = 1;
                    res.status = STATUS_OVF;
                    pending.push_back(res);
                end
                else
                begin
                    row_start[rows_loaded] = edges_loaded;
                    rows_loaded++;
                end
            end
            else if (f == FUNC_EDGE)
            begin
                if (edges_loaded >= EDGE_CAP)
                begin
                    ovf = 1;
                    res.status = STATUS_OVF;
                    pending.push_back(res);
                end
                else
                begin
                    edge_dest[edges_loaded] = d;
                    edge_wt[edges_loaded] = w;
                    edges_loaded++;
                end
            end
            else if (f == FUNC_RUN)
            begin
                runs++;
                run_passes();
                res.status = ovf ? STATUS_OVF : STATUS_DONE;
                pending.push_back(res);
            end
            else
            begin
                res.rank = rank_st[d];
                res.status = STATUS_OK;
                pending.push_back(res);
            end
        endfunction

        function void check_result(logic [RANK_W-1:0] r, logic [STAT_W-1:0] s);
            rank_result_t exp_res;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result rank=%h status=%0d", $time, r, s);
                return;
            end
            exp_res = pending.pop_front();
            if (r !== exp_res.rank)
            begin
                errors++;
                $display("%0t: rank mismatch expected %h actual %h", $time, exp_res.rank, r);
            end
            if (s !== exp_res.status)
            begin
                errors++;
                $display("%0t: status mismatch expected %0d actual %0d",
                         $time, exp_res.status, s);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [FUNC_W-1:0]  func;
    logic [DEST_W-1:0]  dest_node;
    logic [RAW_W-1:0]   weight;
    logic               out_valid;
    logic               out_ready;
    logic [RANK_W-1:0]  rank;
    logic [STAT_W-1:0]  status;

    rank_scoreboard sb;
    int gap_pct;
    int stall_pct;
    int hold_cycles;
    int cur_n;
    int read_span;

    pagerank_push_engine_top uut (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        in_valid = 0;
        func = FUNC_ROW;
        dest_node = '0;
        weight = '0;
        out_ready = 0;
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        sb = new();
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(rank, status);

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("[pagerank_push_engine_top] ERROR");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, int unsigned v);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= PADDR_W'(4 * idx);
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.set_reg(idx, v);
        if (idx == REG_NODE_COUNT)
            cur_n = (v == 0) ? 1 : (v > NODE_CAP) ? NODE_CAP : v;
    endtask

    task automatic send(logic [FUNC_W-1:0] f, logic [DEST_W-1:0] d, logic [RAW_W-1:0] w);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < gap_pct)
                @(posedge clk);
        end
        in_valid <= 1;
        func <= f;
        dest_node <= d;
        weight <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(f, d, w);
    endtask

    task automatic settle();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic run_graph();
        send(FUNC_RUN, DEST_W'($urandom), RAW_W'($urandom));
        if (cur_n > read_span)
            read_span = cur_n;
    endtask

    task automatic read_node();
        int d;
        if ($urandom_range(4) != 0)
            d = $urandom_range(cur_n - 1);
        else
            d = $urandom_range(read_span - 1);
        send(FUNC_READ, DEST_W'(d), RAW_W'($urandom));
    endtask

    function automatic logic [RAW_W-1:0] pick_weight();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int nrows;
        int nedges;
        int nreads;
        rst_n = 0;
        cur_n = 1;
        read_span = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: edge before any row, sink row, zero-sum row, far destination
        write_reg(REG_NODE_COUNT, 2);
        write_reg(REG_ITERATIONS, 255);
        send(FUNC_EDGE, 10'd1023, 16'hFFFF);
        send(FUNC_ROW, 0, 0);
        send(FUNC_EDGE, 10'd1, 16'hFFFF);
        send(FUNC_EDGE, 10'd0, 16'h0);
        send(FUNC_ROW, 0, 0);
        send(FUNC_ROW, 0, 0);
        send(FUNC_EDGE, 10'd1, 16'h0);
        send(FUNC_EDGE, 10'd1023, 16'h0);
        run_graph();
        send(FUNC_READ, 0, 0);
        send(FUNC_READ, 1, 16'hFFFF);
        settle();
        write_reg(REG_NODE_COUNT, 0);
        write_reg(REG_ITERATIONS, 0);
        write_reg(REG_RESTART_PROB, 0);
        run_graph();
        send(FUNC_READ, 0, 0);
        settle();
        write_reg(REG_NODE_COUNT, 2047);
        write_reg(REG_ITERATIONS, 1);
        write_reg(REG_RESTART_PROB, 65535);
        run_graph();
        send(FUNC_READ, 10'd1023, 0);
        send(FUNC_READ, 10'd512, 0);
        send(FUNC_READ, 10'd2, 0);
        settle();

        for (int rnd = 0; rnd < 12; rnd++)
        begin
            case (rnd % 4)
                0: begin gap_pct = 0; stall_pct = 0; end
                1: begin gap_pct = 53; stall_pct = 0; end
                2: begin gap_pct = 0; stall_pct = 53; end
                default: begin gap_pct = 33; stall_pct = 33; end
            endcase
            write_reg(REG_NODE_COUNT, ($urandom_range(5) == 0) ? $urandom_range(200, 1)
                                                              : $urandom_range(48, 1));
            write_reg(REG_ITERATIONS, $urandom_range(20));
            write_reg(REG_RESTART_PROB, $urandom_range(65535));
            nrows = $urandom_range(6, 1);
            for (int r = 0; r < nrows; r++)
            begin
                send(FUNC_ROW, DEST_W'($urandom), RAW_W'($urandom));
                nedges = $urandom_range(6);
                for (int k = 0; k < nedges; k++)
                begin
                    if ($urandom_range(9) == 0)
                        send(FUNC_EDGE, DEST_W'($urandom), pick_weight());
                    else
                        send(FUNC_EDGE, DEST_W'($urandom_range(cur_n - 1)), pick_weight());
                    if ($urandom_range(3) == 0)
                        read_node();
                end
            end
            run_graph();
            nreads = $urandom_range(70, 50);
            for (int k = 0; k < nreads; k++)
            begin
                if (rnd == 5 && k == 10)
                    hold_cycles = 400;
                read_node();
                if (k == nreads / 2 && rnd == 7)
                    settle();
            end
            settle();
        end

        // fill the node store past capacity, then one run flagged as overflow
        gap_pct = 0;
        stall_pct = 0;
        write_reg(REG_NODE_COUNT, 4);
        write_reg(REG_ITERATIONS, 0);
        nrows = NODE_CAP - sb.rows_loaded + 2;
        repeat (nrows) send(FUNC_ROW, DEST_W'($urandom), RAW_W'($urandom));
        run_graph();
        repeat (40) read_node();
        settle();
        repeat (50) @(posedge clk);

        $display("Covered %0d transfers in, %0d results, %0d runs; node store filled to overflow.",
                 sb.items, sb.checked, sb.runs);
        if (sb.errors == 0)
            $display("[pagerank_push_engine_top] OK");
        else
            $display("[pagerank_push_engine_top] ERROR");
        $finish;
    end
endmodule
